/* sv/ftbe_pkg.sv */
`timescale 1ns / 1ps

package ftbe_pkg;

	// Field widths of the item and result ports.
	localparam int X_W  = 16;
	localparam int N_W  = 7;
	localparam int K_W  = 7;
	localparam int F_W  = 16;
	localparam int DF_W = 25;

	// Magnitudes in the quarter-wave sine table are unsigned Q0.15 and never negative.
	localparam int MAG_W = 15;

	// 2*pi in Q24, pi/2 in Q30 and one half in Q1.15.
	localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
	localparam logic        [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [F_W-1:0] HALF_Q15 = 16'sd16384;

	// Saturation limits of the result fields.
	localparam logic signed [F_W-1:0]  VALUE_MAX = 16'sh7fff;
	localparam logic signed [F_W-1:0]  VALUE_MIN = 16'sh8000;
	localparam logic signed [DF_W-1:0] GRAD_MAX  = 25'sh0ffffff;
	localparam logic signed [DF_W-1:0] GRAD_MIN  = 25'sh1000000;

	// Per-item control that rides along with one coordinate through the term unit.
	typedef struct packed {
		logic           zero;
		logic           odd;
		logic [K_W-1:0] k;
	} term_ctl_t;

endpackage

/* sv/ftbe_term.sv */
`timescale 1ns / 1ps

module ftbe_term #(
	parameter int PHASE_BITS  = 16,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_in,
	input  ftbe_pkg::term_ctl_t               ctl_in,
	input  logic [ftbe_pkg::X_W-1:0]          x,
	output logic                              valid_out,
	output logic signed [ftbe_pkg::F_W-1:0]   f,
	output logic signed [ftbe_pkg::DF_W-1:0]  df
);

	localparam int RW   = PHASE_BITS - 2;
	localparam int IW   = $clog2(TABLE_DEPTH + 1);
	localparam int MW   = RW + IW;
	localparam int PW   = ftbe_pkg::K_W + ftbe_pkg::X_W;
	localparam int T_W  = ftbe_pkg::K_W + 1 + ftbe_pkg::F_W;
	localparam int W_W  = T_W + 28;
	localparam logic signed [W_W-1:0] RND_DF = W_W'(64'd1 << 23);

	typedef logic [ftbe_pkg::MAG_W-1:0] rom_t [0:TABLE_DEPTH];

	// Quarter-wave sine, evaluated once at elaboration with a Q30 Taylor series.
	function automatic rom_t build_rom();
		rom_t               tab;
		logic        [63:0] a;
		logic        [63:0] a2;
		logic        [63:0] term;
		logic signed [63:0] s;
		logic signed [63:0] e;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			a = (ftbe_pkg::HALF_PI_Q30 * 64'(i)) / 64'(TABLE_DEPTH);
			a2 = (a * a) >> 30;
			term = a;
			s = signed'(a);
			for (int j = 1; j <= 12; j++) begin
				term = ((term * a2) >> 30) / 64'((2 * j) * (2 * j + 1));
				if (j % 2 == 1) begin
					s = s - signed'(term);
				end else begin
					s = s + signed'(term);
				end
			end
			if (s < 0) begin
				s = 0;
			end
			e = (s * 64'sd32768 + (64'sd1 <<< 29)) >>> 30;
			if (e > 64'sd32767) begin
				e = 64'sd32767;
			end
			tab[i] = e[ftbe_pkg::MAG_W-1:0];
		end
		return tab;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Stage 2: phase k*x mod 1.
	logic [PW-1:0]          prod;
	logic [23:0]            frac24;
	logic                   valid_s2;
	ftbe_pkg::term_ctl_t    ctl_s2;
	logic [PHASE_BITS-1:0]  phase_s2;

	assign prod   = PW'(ctl_in.k) * PW'(x);
	assign frac24 = {prod[ftbe_pkg::X_W-1:0], 8'h00};

	// Stage 3: table index within the quadrant.
	logic [MW-1:0]          idx_mul;
	logic                   valid_s3;
	ftbe_pkg::term_ctl_t    ctl_s3;
	logic [1:0]             quad_s3;
	logic [IW-1:0]          idx_s3;

	assign idx_mul = MW'(phase_s2[RW-1:0]) * MW'(TABLE_DEPTH);

	// Stage 4: table read for sine and cosine.
	logic [IW-1:0]                 mirror;
	logic [IW-1:0]                 addr_sin;
	logic [IW-1:0]                 addr_cos;
	logic                          valid_s4;
	ftbe_pkg::term_ctl_t           ctl_s4;
	logic [ftbe_pkg::MAG_W-1:0]    sin_mag_s4;
	logic [ftbe_pkg::MAG_W-1:0]    cos_mag_s4;
	logic                          neg_sin_s4;
	logic                          neg_cos_s4;

	assign mirror   = IW'(TABLE_DEPTH) - idx_s3;
	assign addr_sin = quad_s3[0] ? mirror : idx_s3;
	assign addr_cos = quad_s3[0] ? idx_s3 : mirror;

	// Stage 5: signed term value and k times the trig value of the derivative.
	logic signed [ftbe_pkg::F_W-1:0] sin_v;
	logic signed [ftbe_pkg::F_W-1:0] cos_v;
	logic signed [ftbe_pkg::F_W-1:0] f_d;
	logic signed [ftbe_pkg::F_W-1:0] trig_d;
	logic                            valid_s5;
	logic signed [ftbe_pkg::F_W-1:0] f_s5;
	logic signed [T_W-1:0]           t_s5;

	always_comb begin
		sin_v = neg_sin_s4 ? -$signed({1'b0, sin_mag_s4}) : $signed({1'b0, sin_mag_s4});
		cos_v = neg_cos_s4 ? -$signed({1'b0, cos_mag_s4}) : $signed({1'b0, cos_mag_s4});
		if (ctl_s4.zero) begin
			f_d = ftbe_pkg::HALF_Q15;
		end else if (ctl_s4.odd) begin
			f_d = sin_v;
		end else begin
			f_d = cos_v;
		end
		// The derivative of sine is cosine, that of cosine is minus sine.
		trig_d = ctl_s4.odd ? cos_v : -sin_v;
	end

	// Stage 6: scale by 2*pi.
	logic                            valid_s6;
	logic signed [ftbe_pkg::F_W-1:0] f_s6;
	logic signed [W_W-1:0]           w_s6;

	// Stage 7: round the Q24 product down to Q10.15.
	logic signed [W_W-1:0]             w_rnd;
	logic                              valid_s7;
	logic signed [ftbe_pkg::F_W-1:0]   f_s7;
	logic signed [ftbe_pkg::DF_W-1:0]  df_s7;

	assign w_rnd = w_s6 + RND_DF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s2 <= valid_in;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2     <= ctl_in;
		phase_s2   <= frac24[23 -: PHASE_BITS];

		ctl_s3     <= ctl_s2;
		quad_s3    <= phase_s2[PHASE_BITS-1 -: 2];
		idx_s3     <= idx_mul[RW +: IW];

		ctl_s4     <= ctl_s3;
		sin_mag_s4 <= SINE_ROM[addr_sin];
		cos_mag_s4 <= SINE_ROM[addr_cos];
		neg_sin_s4 <= quad_s3[1];
		neg_cos_s4 <= quad_s3[1] ^ quad_s3[0];

		f_s5       <= f_d;
		t_s5       <= T_W'($signed({1'b0, ctl_s4.k})) * T_W'(trig_d);

		f_s6       <= f_s5;
		w_s6       <= W_W'(t_s5) * W_W'(ftbe_pkg::TWO_PI_Q24);

		f_s7       <= f_s6;
		df_s7      <= w_rnd[24 +: ftbe_pkg::DF_W];
	end

	assign valid_out = valid_s7;
	assign f         = f_s7;
	assign df        = df_s7;

endmodule

/* sv/fourier_tensor_basis_eval.sv */
// Evaluates one tensor-product Fourier basis function and its gradient at a point
// (u, v) of the unit square. The block is a nine-stage pipeline that takes a new
// transaction in every cycle: busy is always low, and each result appears on value,
// grad_u and grad_v for exactly one cycle with done high, at the end of the pipeline.
// The receiver cannot stall the pipeline, so it must capture every result in the
// cycle it is shown. Each coordinate has its own quarter-wave sine table of
// TABLE_DEPTH+1 entries, read for sine and cosine in the same cycle; the table is
// constant and needs no set-up after reset.
`timescale 1ns / 1ps

module fourier_tensor_basis_eval #(
	parameter int MAX_ORDER   = 32,
	parameter int PHASE_BITS  = 16,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [ftbe_pkg::X_W-1:0]          u,
	input  logic [ftbe_pkg::X_W-1:0]          v,
	input  logic [ftbe_pkg::N_W-1:0]          basis_index,
	output logic                              done,
	output logic signed [ftbe_pkg::F_W-1:0]   value,
	output logic signed [ftbe_pkg::DF_W-1:0]  grad_u,
	output logic signed [ftbe_pkg::DF_W-1:0]  grad_v
);

	localparam int NMAX    = 2 * MAX_ORDER;
	localparam int LATENCY = 9;
	localparam int PV_W    = 2 * ftbe_pkg::F_W;
	localparam int PG_W    = ftbe_pkg::DF_W + ftbe_pkg::F_W;

	assign busy = 1'b0;

	// Stage 1: clamp the basis number and derive the frequency.
	logic [ftbe_pkg::N_W-1:0] n_clamp;
	logic [ftbe_pkg::N_W:0]   k_sum;
	logic                     valid_s1;
	ftbe_pkg::term_ctl_t      ctl_s1;
	logic [ftbe_pkg::X_W-1:0] u_s1;
	logic [ftbe_pkg::X_W-1:0] v_s1;

	always_comb begin
		if (32'(basis_index) > 32'(NMAX)) begin
			n_clamp = ftbe_pkg::N_W'(NMAX);
		end else begin
			n_clamp = basis_index;
		end
		// Odd n rounds up: k = (n + 1) / 2, even n gives k = n / 2.
		k_sum = {1'b0, n_clamp} + {{ftbe_pkg::N_W{1'b0}}, n_clamp[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1.zero <= (n_clamp == '0);
		ctl_s1.odd  <= n_clamp[0];
		ctl_s1.k    <= k_sum[ftbe_pkg::N_W:1];
		u_s1        <= u;
		v_s1        <= v;
	end

	// Stages 2 to 7: one-dimensional term and derivative per coordinate.
	logic                             valid_u_s7;
	logic                             valid_v_s7;
	logic signed [ftbe_pkg::F_W-1:0]  fu_s7;
	logic signed [ftbe_pkg::F_W-1:0]  fv_s7;
	logic signed [ftbe_pkg::DF_W-1:0] dfu_s7;
	logic signed [ftbe_pkg::DF_W-1:0] dfv_s7;

	ftbe_term #(
		.PHASE_BITS  (PHASE_BITS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.ctl_in    (ctl_s1),
		.x         (u_s1),
		.valid_out (valid_u_s7),
		.f         (fu_s7),
		.df        (dfu_s7)
	);

	ftbe_term #(
		.PHASE_BITS  (PHASE_BITS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) v_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.ctl_in    (ctl_s1),
		.x         (v_s1),
		.valid_out (valid_v_s7),
		.f         (fv_s7),
		.df        (dfv_s7)
	);

	// Stage 8: the three products.
	logic                    valid_s8;
	logic signed [PV_W-1:0]  pv_s8;
	logic signed [PG_W-1:0]  pgu_s8;
	logic signed [PG_W-1:0]  pgv_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s8 <= valid_u_s7 && valid_v_s7;
			done     <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		pv_s8  <= PV_W'(fu_s7) * PV_W'(fv_s7);
		pgu_s8 <= PG_W'(dfu_s7) * PG_W'(fv_s7);
		pgv_s8 <= PG_W'(fu_s7) * PG_W'(dfv_s7);
	end

	// Stage 9: round half up by 15 bits and saturate into the result fields.
	logic signed [PV_W-1:0]                pv_rnd;
	logic signed [PG_W-1:0]                pgu_rnd;
	logic signed [PG_W-1:0]                pgv_rnd;
	logic signed [PV_W-16:0]               val_sh;
	logic signed [PG_W-16:0]               gu_sh;
	logic signed [PG_W-16:0]               gv_sh;
	logic signed [ftbe_pkg::F_W-1:0]       val_d;
	logic signed [ftbe_pkg::DF_W-1:0]      gu_d;
	logic signed [ftbe_pkg::DF_W-1:0]      gv_d;

	always_comb begin
		pv_rnd  = pv_s8 + PV_W'(16384);
		pgu_rnd = pgu_s8 + PG_W'(16384);
		pgv_rnd = pgv_s8 + PG_W'(16384);
		val_sh  = pv_rnd[PV_W-1:15];
		gu_sh   = pgu_rnd[PG_W-1:15];
		gv_sh   = pgv_rnd[PG_W-1:15];

		if (val_sh > (PV_W-15)'(ftbe_pkg::VALUE_MAX)) begin
			val_d = ftbe_pkg::VALUE_MAX;
		end else if (val_sh < (PV_W-15)'(ftbe_pkg::VALUE_MIN)) begin
			val_d = ftbe_pkg::VALUE_MIN;
		end else begin
			val_d = val_sh[ftbe_pkg::F_W-1:0];
		end

		if (gu_sh > (PG_W-15)'(ftbe_pkg::GRAD_MAX)) begin
			gu_d = ftbe_pkg::GRAD_MAX;
		end else if (gu_sh < (PG_W-15)'(ftbe_pkg::GRAD_MIN)) begin
			gu_d = ftbe_pkg::GRAD_MIN;
		end else begin
			gu_d = gu_sh[ftbe_pkg::DF_W-1:0];
		end

		if (gv_sh > (PG_W-15)'(ftbe_pkg::GRAD_MAX)) begin
			gv_d = ftbe_pkg::GRAD_MAX;
		end else if (gv_sh < (PG_W-15)'(ftbe_pkg::GRAD_MIN)) begin
			gv_d = ftbe_pkg::GRAD_MIN;
		end else begin
			gv_d = gv_sh[ftbe_pkg::DF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		value  <= val_d;
		grad_u <= gu_d;
		grad_v <= gv_d;
	end

	// Every accepted transaction comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted transaction produced no result after the pipeline latency");

	// No result appears without a transaction accepted at the matching time.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching accepted transaction");

	// The constant basis gives a quarter and a flat gradient.
	a_const_basis: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && basis_index == '0) |->
		##LATENCY (value == 16'sd8192 && grad_u == '0 && grad_v == '0))
		else $error("constant basis did not evaluate to one quarter with zero gradient");

endmodule

/* tb/fourier_tensor_basis_eval_checker.sv */
`timescale 1ns / 1ps

module basis_eval_checker #(
	parameter int MAX_ORDER   = 32,
	parameter int PHASE_BITS  = 16,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [ftbe_pkg::X_W-1:0]          u,
	input  logic [ftbe_pkg::X_W-1:0]          v,
	input  logic [ftbe_pkg::N_W-1:0]          basis_index,
	input  logic                              done,
	input  logic signed [ftbe_pkg::F_W-1:0]   value,
	input  logic signed [ftbe_pkg::DF_W-1:0]  grad_u,
	input  logic signed [ftbe_pkg::DF_W-1:0]  grad_v,
	output int                                failures,
	output int                                outstanding
);

	localparam logic [PHASE_BITS-1:0] QUARTER_TURN = PHASE_BITS'(1) << (PHASE_BITS - 2);

	typedef struct {
		logic [ftbe_pkg::X_W-1:0]          u;
		logic [ftbe_pkg::X_W-1:0]          v;
		logic [ftbe_pkg::N_W-1:0]          n;
		logic signed [ftbe_pkg::F_W-1:0]   value;
		logic signed [ftbe_pkg::DF_W-1:0]  grad_u;
		logic signed [ftbe_pkg::DF_W-1:0]  grad_v;
	} basis_result_t;

	int quarter_sine [0:TABLE_DEPTH];
	basis_result_t expected_results [$];
	int mismatch_count = 0;

	// The quarter-wave table holds sin(pi/2 * i/TABLE_DEPTH) in Q1.15, from a
	// Taylor series evaluated in Q30 integer arithmetic.
	initial begin : fill_table
		longint unsigned a, a2, term;
		longint s, e;
		for (int i = 0; i <= TABLE_DEPTH; i++) begin
			a = (ftbe_pkg::HALF_PI_Q30 * 64'(i)) / 64'(TABLE_DEPTH);
			a2 = (a * a) >> 30;
			term = a;
			s = longint'(a);
			for (int k = 1; k <= 12; k++) begin
				term = ((term * a2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
				if (k % 2 == 1)
					s -= longint'(term);
				else
					s += longint'(term);
			end
			if (s < 0)
				s = 0;
			e = (s * 32768 + (longint'(1) << 29)) >>> 30;
			if (e > 32767)
				e = 32767;
			quarter_sine[i] = int'(e);
		end
	end

	function automatic longint round_half_up(input longint x, input int shift);
		return (x + (longint'(1) << (shift - 1))) >>> shift;
	endfunction

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

	function automatic longint table_sine(input logic [PHASE_BITS-1:0] phase);
		logic [1:0] quad;
		longint unsigned idx;
		longint t;
		quad = phase[PHASE_BITS-1 -: 2];
		idx = (64'(phase[PHASE_BITS-3:0]) * 64'(TABLE_DEPTH)) >> (PHASE_BITS - 2);
		if (quad[0])
			idx = 64'(TABLE_DEPTH) - idx;
		t = quarter_sine[idx];
		return quad[1] ? -t : t;
	endfunction

	// One-dimensional term f (Q1.15) and its derivative (Q10.15) at coordinate x.
	function automatic void fourier_term(input logic [ftbe_pkg::X_W-1:0] x, input int n,
					     output longint f, output longint df);
		longint k, w, trig;
		longint unsigned p;
		logic [PHASE_BITS-1:0] phase;
		if (n == 0) begin
			f = ftbe_pkg::HALF_Q15;
			df = 0;
		end else begin
			k = (n % 2 == 1) ? (n + 1) / 2 : n / 2;
			p = 64'(k * longint'(x)) << 8;
			phase = PHASE_BITS'(p >> (24 - PHASE_BITS));
			w = k * ftbe_pkg::TWO_PI_Q24;
			if (n % 2 == 1) begin
				f = table_sine(phase);
				trig = table_sine(phase + QUARTER_TURN);
				df = round_half_up(w * trig, 24);
			end else begin
				f = table_sine(phase + QUARTER_TURN);
				trig = table_sine(phase);
				df = round_half_up(-(w * trig), 24);
			end
		end
	endfunction

	always @(posedge clk) begin : watch
		basis_result_t want;
		longint fu, dfu, fv, dfv;
		int n;
		if (arst_n) begin
			if (start && !busy) begin
				n = (basis_index > 2 * MAX_ORDER) ? 2 * MAX_ORDER : int'(basis_index);
				fourier_term(u, n, fu, dfu);
				fourier_term(v, n, fv, dfv);
				want.u = u;
				want.v = v;
				want.n = basis_index;
				want.value = ftbe_pkg::F_W'(clamp(round_half_up(fu * fv, 15),
					ftbe_pkg::VALUE_MIN, ftbe_pkg::VALUE_MAX));
				want.grad_u = ftbe_pkg::DF_W'(clamp(round_half_up(dfu * fv, 15),
					ftbe_pkg::GRAD_MIN, ftbe_pkg::GRAD_MAX));
				want.grad_v = ftbe_pkg::DF_W'(clamp(round_half_up(fu * dfv, 15),
					ftbe_pkg::GRAD_MIN, ftbe_pkg::GRAD_MAX));
				expected_results.push_back(want);
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result without a pending transaction: %0d %0d %0d",
							 $time, value, grad_u, grad_v);
				end else begin
					want = expected_results.pop_front();
					if (value !== want.value || grad_u !== want.grad_u ||
					    grad_v !== want.grad_v) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: u=%h v=%h n=%0d expected %0d %0d %0d, got %0d %0d %0d",
								 $time, want.u, want.v, want.n, want.value,
								 want.grad_u, want.grad_v, value, grad_u, grad_v);
					end
				end
			end
		end
		failures <= mismatch_count;
		outstanding <= expected_results.size();
	end

endmodule

/* tb/tb_fourier_tensor_basis_eval.sv */
`timescale 1ns / 1ps

module tb_fourier_tensor_basis_eval;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 560;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [ftbe_pkg::X_W-1:0]            u = '0;
	logic [ftbe_pkg::X_W-1:0]            v = '0;
	logic [ftbe_pkg::N_W-1:0]            basis_index = '0;
	logic                                done;
	logic signed [ftbe_pkg::F_W-1:0]     value;
	logic signed [ftbe_pkg::DF_W-1:0]    grad_u;
	logic signed [ftbe_pkg::DF_W-1:0]    grad_v;
	int                                  failures;
	int                                  outstanding;
	int                                  idle_pct = 0;
	int                                  quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	fourier_tensor_basis_eval dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.u(u), .v(v), .basis_index(basis_index),
		.done(done), .value(value), .grad_u(grad_u), .grad_v(grad_v)
	);

	basis_eval_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.u(u), .v(v), .basis_index(basis_index),
		.done(done), .value(value), .grad_u(grad_u), .grad_v(grad_v),
		.failures(failures), .outstanding(outstanding)
	);

	// Ends the run if neither side completes a transaction for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic issue_point(input logic [ftbe_pkg::X_W-1:0] xu,
				   input logic [ftbe_pkg::X_W-1:0] xv,
				   input logic [ftbe_pkg::N_W-1:0] n);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		u <= xu;
		v <= xv;
		basis_index <= n;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Coordinates lean toward the ends of the interval and the quadrant boundaries,
	// where the table mirroring and sign changes happen.
	function automatic logic [ftbe_pkg::X_W-1:0] pick_coord();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return (ftbe_pkg::X_W'($urandom_range(3)) << (ftbe_pkg::X_W - 2))
				+ ftbe_pkg::X_W'($urandom_range(31)) - ftbe_pkg::X_W'(16);
			default: return ftbe_pkg::X_W'($urandom);
		endcase
	endfunction

	task automatic issue_random_point();
		logic [ftbe_pkg::N_W-1:0] n;
		if ($urandom_range(99) < 80)
			n = ftbe_pkg::N_W'($urandom_range(64));
		else
			n = ftbe_pkg::N_W'($urandom_range(127, 65));
		issue_point(pick_coord(), pick_coord(), n);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_point(16'h0000, 16'h0000, 7'd0);
		issue_point(16'hffff, 16'hffff, 7'd0);
		issue_point(16'h0000, 16'h0000, 7'd1);
		issue_point(16'h0000, 16'h0000, 7'd2);
		issue_point(16'hffff, 16'hffff, 7'd1);
		issue_point(16'hffff, 16'h0000, 7'd2);
		issue_point(16'h4000, 16'h4000, 7'd1);
		issue_point(16'h4000, 16'hc000, 7'd2);
		issue_point(16'h8000, 16'h8000, 7'd1);
		issue_point(16'hc000, 16'h4000, 7'd3);
		issue_point(16'h2000, 16'h6000, 7'd4);
		issue_point(16'h0001, 16'hfffe, 7'd64);
		issue_point(16'h0400, 16'h0200, 7'd63);
		issue_point(16'h1234, 16'h8765, 7'd64);
		issue_point(16'h1234, 16'h8765, 7'd65);
		issue_point(16'h1234, 16'h8765, 7'd127);
		issue_point(16'hffff, 16'h0001, 7'd127);
		issue_point(16'h5555, 16'haaaa, 7'd5);
		issue_point(16'haaaa, 16'h5555, 7'd6);
		issue_point(16'h0080, 16'hff80, 7'd32);
		issue_point(16'h3fff, 16'h7fff, 7'd33);
		issue_point(16'hbfff, 16'hffff, 7'd62);

		idle_pct = 32;
		repeat (RANDOM_PER_PHASE) issue_random_point();
		idle_pct = 52;
		repeat (RANDOM_PER_PHASE) issue_random_point();
		idle_pct = 0;
		repeat (RANDOM_PER_PHASE) issue_random_point();
		start <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
